/* sv/dtc_pkg.sv */
// shared types and constants for the decision tree classifier
`timescale 1ns / 1ps
`default_nettype none

package dtc_pkg;

  localparam int unsigned FIELD_W           = 16;
  localparam int unsigned CLS_W             = 2;
  localparam int unsigned FEAT_SEL_W        = 2;
  localparam int unsigned NUM_FEATURES      = 4;
  localparam int unsigned IDX_W             = 8;
  localparam int unsigned TABLE_SIZE        = 255;
  localparam int unsigned NODE_W            = 1 + FEAT_SEL_W + FIELD_W + CLS_W;
  localparam int unsigned DEF_MAX_DEPTH     = 7;
  localparam int unsigned DEF_FEATURE_WIDTH = 16;

  localparam logic [CLS_W-1:0] CLS_L = 2'd0;
  localparam logic [CLS_W-1:0] CLS_B = 2'd2;

  typedef enum logic {
    OP_WRITE    = 1'b0,
    OP_CLASSIFY = 1'b1
  } op_e;

  typedef struct packed {
    logic                  is_leaf;
    logic [FEAT_SEL_W-1:0] feature;
    logic [FIELD_W-1:0]    threshold;
    logic [CLS_W-1:0]      cls;
  } node_t;

  typedef struct packed {
    logic wr;
    logic start;
    logic step;
    logic finish;
    logic push;
  } dtc_cmd_t;

  typedef struct packed {
    logic done;
  } dtc_sts_t;

endpackage

`default_nettype wire

/* sv/dtc_ram.sv */
// generic single write port ram with registered read
`timescale 1ns / 1ps
`default_nettype none

module dtc_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk_i,
  input  wire logic             we_i,
  input  wire logic [AW-1:0]    waddr_i,
  input  wire logic [WIDTH-1:0] wdata_i,
  input  wire logic [AW-1:0]    raddr_i,
  output logic      [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

/* sv/dtc_ctrl.sv */
// controller state machine for the tree walk and result handoff
`timescale 1ns / 1ps
`default_nettype none

module dtc_ctrl
  import dtc_pkg::*;
(
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     in_valid_i,
  output logic          in_stall_o,
  input  wire logic     opcode_i,
  output logic          out_valid_o,
  input  wire logic     out_stall_i,
  input  wire dtc_sts_t sts_i,
  output dtc_cmd_t      cmd_o
);

  typedef enum logic [2:0] {
    S_IDLE = 3'b001,
    S_WALK = 3'b010,
    S_PUSH = 3'b100
  } state_e;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   accept;
  logic   slot_free;

  assign in_stall_o = (state_q != S_IDLE);
  assign accept     = in_valid_i && !in_stall_o;
  assign slot_free  = !out_valid_q || !out_stall_i;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (op_e'(opcode_i) == OP_CLASSIFY) begin
            cmd_o.start = 1'b1;
            state_d     = S_WALK;
          end else begin
            cmd_o.wr = 1'b1;
          end
        end
      end
      S_WALK: begin
        if (sts_i.done) begin
          cmd_o.finish = 1'b1;
          state_d      = S_PUSH;
        end else begin
          cmd_o.step = 1'b1;
        end
      end
      S_PUSH: begin
        if (slot_free) begin
          cmd_o.push = 1'b1;
          state_d    = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.push) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

/* sv/dtc_datapath.sv */
// node table, valid marks, sample registers and walk datapath
`timescale 1ns / 1ps
`default_nettype none

module dtc_datapath
  import dtc_pkg::*;
#(
  parameter int unsigned MAX_DEPTH     = DEF_MAX_DEPTH,
  parameter int unsigned FEATURE_WIDTH = DEF_FEATURE_WIDTH
) (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire dtc_cmd_t                  cmd_i,
  output dtc_sts_t                       sts_o,
  input  wire logic        [IDX_W-1:0]   node_index_i,
  input  wire logic                      node_is_leaf_i,
  input  wire logic        [FEAT_SEL_W-1:0] node_feature_i,
  input  wire logic signed [FIELD_W-1:0] node_threshold_i,
  input  wire logic        [CLS_W-1:0]   node_class_i,
  input  wire logic signed [FIELD_W-1:0] sample_a_i,
  input  wire logic signed [FIELD_W-1:0] sample_b_i,
  input  wire logic signed [FIELD_W-1:0] sample_c_i,
  input  wire logic signed [FIELD_W-1:0] sample_d_i,
  output logic             [CLS_W-1:0]   predicted_class_o,
  output logic                           walk_error_o
);

  localparam int unsigned CMP_W = (FEATURE_WIDTH < FIELD_W) ? FEATURE_WIDTH : FIELD_W;
  localparam int unsigned LVL_W = $clog2(MAX_DEPTH + 1);

  logic [TABLE_SIZE-1:0] vld_q;
  logic                  vld_rd_q, vld_rd_d;
  logic                  oob_q, oob_d;
  logic [IDX_W-1:0]      idx_q, idx_d;
  logic [LVL_W-1:0]      level_q, level_d;
  logic [FIELD_W-1:0]    samp_q [NUM_FEATURES];
  logic [CLS_W-1:0]      res_cls_q;
  logic                  res_err_q;
  logic [CLS_W-1:0]      out_cls_q;
  logic                  out_err_q;

  logic [NODE_W-1:0]     rdata;
  node_t                 node;
  node_t                 wr_node;
  logic                  wr_en;
  logic [IDX_W-1:0]      rd_addr;
  logic [IDX_W:0]        child;
  logic                  go_left;
  logic                  done;
  logic                  err;
  logic [CLS_W-1:0]      cls;
  logic [FIELD_W-1:0]    val_sel;

  assign wr_node.is_leaf   = node_is_leaf_i;
  assign wr_node.feature   = node_feature_i;
  assign wr_node.threshold = node_threshold_i;
  assign wr_node.cls       = node_class_i;
  assign wr_en = cmd_i.wr && (node_index_i != IDX_W'(TABLE_SIZE));

  dtc_ram #(
    .WIDTH (NODE_W),
    .DEPTH (TABLE_SIZE)
  ) u_node_ram (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (node_index_i),
    .wdata_i (wr_node),
    .raddr_i (rd_addr),
    .rdata_o (rdata)
  );

  assign node    = node_t'(rdata);
  assign val_sel = samp_q[node.feature];
  assign go_left = $signed(val_sel[CMP_W-1:0]) <= $signed(node.threshold[CMP_W-1:0]);
  assign child   = {idx_q, 1'b0} + (go_left ? (IDX_W+1)'(1) : (IDX_W+1)'(2));
  assign rd_addr = cmd_i.start ? '0 : child[IDX_W-1:0];

  always_comb begin
    done = 1'b0;
    err  = 1'b0;
    cls  = CLS_L;
    if (oob_q || !vld_rd_q) begin
      done = 1'b1;
      err  = 1'b1;
    end else if (node.is_leaf) begin
      done = 1'b1;
      cls  = (node.cls > CLS_B) ? CLS_B : node.cls;
    end else if (level_q >= LVL_W'(MAX_DEPTH)) begin
      done = 1'b1;
      err  = 1'b1;
    end
  end

  assign sts_o.done = done;

  // next walk position and lookup of its valid mark
  always_comb begin
    idx_d    = idx_q;
    level_d  = level_q;
    oob_d    = oob_q;
    vld_rd_d = vld_rd_q;
    if (cmd_i.start) begin
      idx_d    = '0;
      level_d  = '0;
      oob_d    = 1'b0;
      vld_rd_d = vld_q[0];
    end else if (cmd_i.step) begin
      idx_d    = child[IDX_W-1:0];
      level_d  = level_q + LVL_W'(1);
      oob_d    = (child >= (IDX_W+1)'(TABLE_SIZE));
      vld_rd_d = oob_d ? 1'b0 : vld_q[child[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
      oob_q    <= 1'b0;
      idx_q    <= '0;
      level_q  <= '0;
    end else begin
      if (wr_en) begin
        vld_q[node_index_i] <= 1'b1;
      end
      vld_rd_q <= vld_rd_d;
      oob_q    <= oob_d;
      idx_q    <= idx_d;
      level_q  <= level_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      samp_q[0] <= sample_a_i;
      samp_q[1] <= sample_b_i;
      samp_q[2] <= sample_c_i;
      samp_q[3] <= sample_d_i;
    end
    if (cmd_i.finish) begin
      res_cls_q <= cls;
      res_err_q <= err;
    end
    if (cmd_i.push) begin
      out_cls_q <= res_cls_q;
      out_err_q <= res_err_q;
    end
  end

  assign predicted_class_o = out_cls_q;
  assign walk_error_o      = out_err_q;

endmodule

`default_nettype wire

/* sv/decision_tree_classifier.sv */
// top level of the decision tree classifier
//
//   channel | direction | handshake               | fields
//   --------+-----------+-------------------------+-----------------------------------
//   in      | input     | in_valid_i / in_stall_o | opcode, node_*, sample_a..sample_d
//   out     | output    | out_valid_o/out_stall_i | predicted_class, walk_error
//
// a node write word leaves the block ready again the next cycle
// a classify word visits N nodes, N from 1 to MAX_DEPTH + 1, with one node table read per level
// through the ram read port
// reset clears the valid marks of all nodes at once, no clearing pass
// a finished result waits in the output register while the next word is taken in
`timescale 1ns / 1ps
`default_nettype none

module decision_tree_classifier
  import dtc_pkg::*;
#(
  parameter int unsigned MAX_DEPTH     = DEF_MAX_DEPTH,
  parameter int unsigned FEATURE_WIDTH = DEF_FEATURE_WIDTH
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic                         opcode_i,
  input  wire logic        [IDX_W-1:0]      node_index_i,
  input  wire logic                         node_is_leaf_i,
  input  wire logic        [FEAT_SEL_W-1:0] node_feature_i,
  input  wire logic signed [FIELD_W-1:0]    node_threshold_i,
  input  wire logic        [CLS_W-1:0]      node_class_i,
  input  wire logic signed [FIELD_W-1:0]    sample_a_i,
  input  wire logic signed [FIELD_W-1:0]    sample_b_i,
  input  wire logic signed [FIELD_W-1:0]    sample_c_i,
  input  wire logic signed [FIELD_W-1:0]    sample_d_i,
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic             [CLS_W-1:0]      predicted_class_o,
  output logic                              walk_error_o
);

  dtc_cmd_t cmd;
  dtc_sts_t sts;

  dtc_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .opcode_i    (opcode_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dtc_datapath #(
    .MAX_DEPTH     (MAX_DEPTH),
    .FEATURE_WIDTH (FEATURE_WIDTH)
  ) u_datapath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .sts_o             (sts),
    .node_index_i      (node_index_i),
    .node_is_leaf_i    (node_is_leaf_i),
    .node_feature_i    (node_feature_i),
    .node_threshold_i  (node_threshold_i),
    .node_class_i      (node_class_i),
    .sample_a_i        (sample_a_i),
    .sample_b_i        (sample_b_i),
    .sample_c_i        (sample_c_i),
    .sample_d_i        (sample_d_i),
    .predicted_class_o (predicted_class_o),
    .walk_error_o      (walk_error_o)
  );

endmodule

`default_nettype wire

/* sv/dtc_checker.sv */
// port level checks for the decision tree classifier, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module dtc_checker
  import dtc_pkg::*;
(
  input wire logic             clk_i,
  input wire logic             rst_ni,
  input wire logic             in_valid_i,
  input wire logic             in_stall_o,
  input wire logic             opcode_i,
  input wire logic             out_valid_o,
  input wire logic             out_stall_i,
  input wire logic [CLS_W-1:0] predicted_class_o,
  input wire logic             walk_error_o
);

  logic in_acc;

  assign in_acc = in_valid_i && !in_stall_o;

  // a stalled result word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(predicted_class_o) && $stable(walk_error_o))
    else $error("result word changed while stalled");

  // an error result carries class zero
  a_err_cls: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && walk_error_o |-> predicted_class_o == CLS_L)
    else $error("error result with nonzero class");

  // the reserved class code never leaves the block
  a_cls_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> predicted_class_o <= CLS_B)
    else $error("reserved class code on output");

  // a classify word keeps the input busy for the walk
  a_walk_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_CLASSIFY) |=> in_stall_o)
    else $error("input ready right after a classify word");

  // a node write leaves the input ready in the next cycle
  a_write_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc && (opcode_i == OP_WRITE) |=> !in_stall_o)
    else $error("input busy after a node write");

endmodule

bind decision_tree_classifier dtc_checker u_dtc_checker (
  .clk_i             (clk_i),
  .rst_ni            (rst_ni),
  .in_valid_i        (in_valid_i),
  .in_stall_o        (in_stall_o),
  .opcode_i          (opcode_i),
  .out_valid_o       (out_valid_o),
  .out_stall_i       (out_stall_i),
  .predicted_class_o (predicted_class_o),
  .walk_error_o      (walk_error_o)
);

`default_nettype wire

/* verif/testbench.sv */
// testbench for the decision tree classifier: directed table and random words against a predictor
`timescale 1ns / 1ps

module testbench;
  import dtc_pkg::*;

  localparam int unsigned DEPTH      = DEF_MAX_DEPTH;
  localparam int unsigned NUM_ITEMS  = 1450;
  localparam int unsigned NUM_DIR    = 26;
  localparam int unsigned IDLE_LIMIT = 3000;
  localparam int unsigned HOLD_AFTER = 200;
  localparam int unsigned HOLD_LEN   = 400;
  localparam int unsigned MAX_SHOWN  = 10;

  localparam logic [CLS_W-1:0]   CLS_R = 2'd1;
  localparam logic [FIELD_W-1:0] S_MIN = 16'h8000;
  localparam logic [FIELD_W-1:0] S_MAX = 16'h7fff;
  localparam logic [FIELD_W-1:0] S_0   = 16'h0000;

  typedef struct packed {
    op_e                   op;
    logic [IDX_W-1:0]      idx;
    logic                  leaf;
    logic [FEAT_SEL_W-1:0] feat;
    logic [FIELD_W-1:0]    thr;
    logic [CLS_W-1:0]      cls;
    logic [FIELD_W-1:0]    a;
    logic [FIELD_W-1:0]    b;
    logic [FIELD_W-1:0]    c;
    logic [FIELD_W-1:0]    d;
    logic                  fixed;
    logic [CLS_W-1:0]      fixed_cls;
    logic                  fixed_err;
    logic                  drain;
  } dtc_word_t;

  typedef struct packed {
    logic [CLS_W-1:0] cls;
    logic             err;
  } dtc_result_t;

  logic clk;
  logic rst_n;
  logic in_valid;
  logic in_stall;
  logic out_valid;
  logic out_stall;
  logic [CLS_W-1:0] predicted_class;
  logic walk_error;
  dtc_word_t cur;

  dtc_word_t   dir_tbl [NUM_DIR];
  dtc_word_t   word_q [$];
  dtc_result_t pending_class_q [$];
  dtc_result_t want;
  node_t       node_tbl [TABLE_SIZE];
  bit          node_set [TABLE_SIZE];
  logic [FIELD_W-1:0] thr_pool [4];

  int unsigned n_items;
  int unsigned n_results = 0;
  int unsigned n_fail = 0;
  int unsigned idle_cycles = 0;
  bit          drain_next;

  decision_tree_classifier #(
    .MAX_DEPTH     (DEPTH),
    .FEATURE_WIDTH (DEF_FEATURE_WIDTH)
  ) dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .opcode_i          (cur.op),
    .node_index_i      (cur.idx),
    .node_is_leaf_i    (cur.leaf),
    .node_feature_i    (cur.feat),
    .node_threshold_i  (cur.thr),
    .node_class_i      (cur.cls),
    .sample_a_i        (cur.a),
    .sample_b_i        (cur.b),
    .sample_c_i        (cur.c),
    .sample_d_i        (cur.d),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .predicted_class_o (predicted_class),
    .walk_error_o      (walk_error)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    rst_n = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
  end

  function automatic dtc_result_t classify_sample(input dtc_word_t w);
    dtc_result_t res;
    logic [NUM_FEATURES-1:0][FIELD_W-1:0] smp;
    node_t nd;
    int unsigned idx;
    int unsigned lvl;
    res = '{cls: CLS_L, err: 1'b0};
    smp = {w.d, w.c, w.b, w.a};
    idx = 0;
    for (lvl = 0; lvl <= DEPTH; lvl++) begin
      if (idx >= TABLE_SIZE || !node_set[idx]) begin
        res.err = 1'b1;
        return res;
      end
      nd = node_tbl[idx];
      if (nd.is_leaf) begin
        res.cls = (nd.cls > CLS_B) ? CLS_B : nd.cls;
        return res;
      end
      if (lvl == DEPTH) begin
        res.err = 1'b1;
        return res;
      end
      idx = ($signed(smp[nd.feature]) <= $signed(nd.threshold)) ? 2 * idx + 1 : 2 * idx + 2;
    end
    return res;
  endfunction

  function automatic dtc_word_t rand_word();
    dtc_word_t w;
    w = '0;
    w.op   = op_e'($urandom_range(0, 1));
    w.idx  = 8'($urandom);
    w.leaf = 1'($urandom);
    w.feat = 2'($urandom);
    w.thr  = 16'($urandom);
    w.cls  = 2'($urandom);
    w.a    = 16'($urandom);
    w.b    = 16'($urandom);
    w.c    = 16'($urandom);
    w.d    = 16'($urandom);
    return w;
  endfunction

  function automatic logic [FIELD_W-1:0] sample_value();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 60) return 16'(thr_pool[$urandom_range(0, 3)] + $urandom_range(0, 2) - 1);
    if (r < 65) return S_MIN;
    if (r < 70) return S_MAX;
    return 16'($urandom);
  endfunction

  task automatic add_word(input dtc_word_t w);
    w.drain = drain_next;
    drain_next = 1'b0;
    word_q.insert(word_q.size(), w);
    // a write to index 255 is dropped by the block
    if (!(w.op == OP_WRITE && w.idx >= TABLE_SIZE)) n_items++;
  endtask

  task automatic build_tree();
    int unsigned node_q [$];
    int unsigned lvl_q [$];
    int unsigned r;
    int unsigned depth_lim;
    int unsigned leaf_pct;
    int unsigned i;
    int unsigned lvl;
    int unsigned k;
    bit broken;
    dtc_word_t w;
    r = $urandom_range(0, 99);
    depth_lim = (r < 80) ? $urandom_range(1, 4) : (r < 95) ? $urandom_range(5, 7) : DEPTH + 1;
    leaf_pct = (depth_lim > 4) ? 45 : 20;
    broken = ($urandom_range(0, 9) == 0);
    for (k = 0; k < 4; k++) thr_pool[k] = 16'($urandom);
    node_q.insert(node_q.size(), 0);
    lvl_q.insert(lvl_q.size(), 0);
    while (node_q.size() != 0) begin
      i = node_q.pop_front();
      lvl = lvl_q.pop_front();
      w = rand_word();
      w.op = OP_WRITE;
      w.idx = 8'(i);
      if (lvl >= depth_lim || (lvl > 0 && $urandom_range(0, 99) < leaf_pct)) begin
        w.leaf = 1'b1;
      end else begin
        w.leaf = 1'b0;
        w.thr = thr_pool[$urandom_range(0, 3)];
        if (2 * i + 2 < TABLE_SIZE) begin
          node_q.insert(node_q.size(), 2 * i + 1);
          lvl_q.insert(lvl_q.size(), lvl + 1);
          node_q.insert(node_q.size(), 2 * i + 2);
          lvl_q.insert(lvl_q.size(), lvl + 1);
        end
      end
      // a broken sequence leaves some nodes out
      if (!broken || $urandom_range(0, 3) != 0) add_word(w);
    end
    repeat ($urandom_range(4, 12)) begin
      w = rand_word();
      w.op = OP_CLASSIFY;
      w.a = sample_value();
      w.b = sample_value();
      w.c = sample_value();
      w.d = sample_value();
      add_word(w);
    end
  endtask

  task automatic make_stimulus();
    int unsigned r;
    int unsigned k;
    bit half_done;
    dtc_word_t w;
    // op, index, leaf, feature, threshold, class, a, b, c, d, fixed, class, error, drain
    dir_tbl[0]  = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_0, S_0, S_0, 1'b1, CLS_L, 1'b1, 1'b0};
    dir_tbl[1]  = '{OP_WRITE, 8'd255, 1'b1, 2'd3, S_MAX, 2'd1,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[2]  = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_MAX, S_MAX, S_MAX, S_MAX, 1'b1, CLS_L, 1'b1, 1'b0};
    dir_tbl[3]  = '{OP_WRITE, 8'd0, 1'b1, 2'd0, S_0, 2'd3,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[4]  = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_MIN, S_MIN, S_MIN, S_MIN, 1'b1, CLS_B, 1'b0, 1'b0};
    dir_tbl[5]  = '{OP_WRITE, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[6]  = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_0, S_0, S_0, 1'b1, CLS_L, 1'b1, 1'b0};
    dir_tbl[7]  = '{OP_WRITE, 8'd1, 1'b1, 2'd0, S_0, CLS_L,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[8]  = '{OP_WRITE, 8'd2, 1'b1, 2'd0, S_0, CLS_R,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[9]  = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_MAX, S_MAX, S_MAX, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[10] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    16'h0001, S_MIN, S_MIN, S_MIN, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[11] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_MIN, S_MAX, S_MAX, S_MAX, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[12] = '{OP_WRITE, 8'd0, 1'b0, 2'd3, S_MIN, 2'd0,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[13] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_MAX, S_MAX, S_MAX, S_MIN, 1'b1, CLS_L, 1'b0, 1'b0};
    dir_tbl[14] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_MIN, S_MIN, S_MIN, S_MAX, 1'b1, CLS_R, 1'b0, 1'b0};
    // rightmost path down to the deepest level
    for (k = 0; k < DEPTH + 1; k++) begin
      dir_tbl[15 + k] = '{OP_WRITE, 8'((1 << (k + 1)) - 2), 1'b0, 2'd2, S_MIN, 2'd0,
                          S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    end
    dir_tbl[23] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_0, S_MAX, S_0, 1'b1, CLS_L, 1'b1, 1'b0};
    dir_tbl[24] = '{OP_WRITE, 8'd254, 1'b1, 2'd0, S_0, CLS_B,
                    S_0, S_0, S_0, S_0, 1'b0, CLS_L, 1'b0, 1'b0};
    dir_tbl[25] = '{OP_CLASSIFY, 8'd0, 1'b0, 2'd0, S_0, 2'd0,
                    S_0, S_0, S_MAX, S_0, 1'b1, CLS_B, 1'b0, 1'b0};
    foreach (dir_tbl[j]) add_word(dir_tbl[j]);

    drain_next = 1'b1;
    half_done = 1'b0;
    while (n_items < NUM_ITEMS) begin
      if (!half_done && n_items >= NUM_ITEMS / 2) begin
        drain_next = 1'b1;
        half_done = 1'b1;
      end
      r = $urandom_range(0, 99);
      if (r < 70) begin
        build_tree();
      end else if (r < 85) begin
        w = rand_word();
        w.op = OP_WRITE;
        add_word(w);
      end else begin
        w = rand_word();
        w.op = OP_CLASSIFY;
        add_word(w);
      end
    end
  endtask

  task automatic note_fail(input string msg);
    n_fail++;
    if (n_fail <= MAX_SHOWN) $display("%s", msg);
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        n_results++;
        if (pending_class_q.size() == 0) begin
          note_fail($sformatf("unexpected word: class %0d error %0b",
                              predicted_class, walk_error));
        end else begin
          want = pending_class_q.pop_front();
          if (predicted_class !== want.cls || walk_error !== want.err) begin
            note_fail($sformatf("mismatch: class %0d error %0b, wanted class %0d error %0b",
                                predicted_class, walk_error, want.cls, want.err));
          end
        end
      end
      if (in_valid && !in_stall) begin
        if (cur.op == OP_WRITE) begin
          if (cur.idx < TABLE_SIZE) begin
            node_tbl[cur.idx] = '{is_leaf: cur.leaf, feature: cur.feat,
                                  threshold: cur.thr, cls: cur.cls};
            node_set[cur.idx] = 1'b1;
          end
        end else if (cur.fixed) begin
          pending_class_q.insert(pending_class_q.size(),
                                 '{cls: cur.fixed_cls, err: cur.fixed_err});
        end else begin
          pending_class_q.insert(pending_class_q.size(), classify_sample(cur));
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
    end
  end

  initial begin : receiver
    int unsigned r;
    bit held;
    out_stall = 1'b0;
    held = 1'b0;
    wait (rst_n);
    forever begin
      @(negedge clk);
      r = $urandom_range(0, 99);
      if (!held && n_results >= HOLD_AFTER) begin
        // long hold-off so the block fills and stalls its input
        held = 1'b1;
        out_stall = 1'b1;
        repeat (HOLD_LEN) @(negedge clk);
      end else if (r < 2) begin
        out_stall = 1'b1;
        repeat ($urandom_range(20, 60)) @(negedge clk);
      end else if (r < 5) begin
        out_stall = 1'b0;
        repeat ($urandom_range(30, 100)) @(negedge clk);
      end else begin
        out_stall = (r < 35);
      end
    end
  end

  initial begin : watchdog
    wait (idle_cycles >= IDLE_LIMIT);
    $display("simulation failed");
    $finish;
  end

  initial begin : driver
    int unsigned gap;
    int unsigned burst_left;
    int unsigned r;
    in_valid = 1'b0;
    cur = '0;
    n_items = 0;
    drain_next = 1'b0;
    burst_left = 0;
    make_stimulus();
    wait (rst_n);
    @(negedge clk);
    foreach (word_q[n]) begin
      r = $urandom_range(0, 99);
      if (burst_left != 0) begin
        burst_left--;
        gap = 0;
      end else if (r < 3) begin
        burst_left = $urandom_range(20, 60);
        gap = 0;
      end else if (r < 60) begin
        gap = 0;
      end else if (r < 90) begin
        gap = $urandom_range(1, 3);
      end else if (r < 97) begin
        gap = $urandom_range(4, 10);
      end else begin
        gap = $urandom_range(20, 50);
      end
      if (word_q[n].drain) begin
        in_valid = 1'b0;
        while (pending_class_q.size() != 0) @(negedge clk);
      end
      if (gap != 0) begin
        in_valid = 1'b0;
        repeat (gap) @(negedge clk);
      end
      cur = word_q[n];
      in_valid = 1'b1;
      @(posedge clk);
      while (in_stall) @(posedge clk);
      @(negedge clk);
    end
    in_valid = 1'b0;
    while (pending_class_q.size() != 0) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
    if (n_fail == 0 && pending_class_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
